// ----- sv/emr_pkg.sv -----
// shared types and constants for the midpoint ellipse rasterizer
package emr_pkg;

  localparam int PT_W   = 14;
  localparam int GRID_W = 13;

  localparam logic [GRID_W-1:0] GRID_RESET = 13'd4096;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    RG_IDLE = 2'd0,
    RG_ONE  = 2'd1,
    RG_TWO  = 2'd2,
    RG_DONE = 2'd3
  } region_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SET_A2,
    DP_SET_B2,
    DP_INIT,
    DP_ACC_SET,
    DP_ACC_ADD,
    DP_ENTER_R2,
    DP_FINISH,
    DP_UPDATE
  } dp_op_t;

  typedef enum logic [2:0] {
    MS_AA,
    MS_BB,
    MS_A2B,
    MS_XSXS,
    MS_B2P,
    MS_YSYS,
    MS_A2P,
    MS_A2B2
  } mul_sel_t;

  typedef struct packed {
    dp_op_t     op;
    mul_sel_t   mul_sel;
    logic       out_load;
    logic       out_point;
    logic [2:0] out_idx;
    logic       out_last;
    logic       out_done;
  } dp_cmd_t;

  typedef struct packed {
    region_t region;
    logic    step_less;
    logic    walk_y_neg;
    logic    walk_y_zero;
    logic    diag;
  } dp_stat_t;

endpackage

// ----- sv/emr_ctrl.sv -----
// controller state machine for the ellipse walk
module emr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  output logic              out_valid,
  input  logic              out_ready,
  input  emr_pkg::dp_stat_t stat,
  output emr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_AB,
    ST_INIT,
    ST_XS,
    ST_B2XS,
    ST_YS,
    ST_A2YS,
    ST_A2B2,
    ST_ENTER,
    ST_CHECK,
    ST_EMIT,
    ST_UPDATE,
    ST_ACK
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       eight, eight_next;
  logic       done_flag, done_flag_next;
  logic       out_valid_next;
  logic       slot_free;
  logic       emit_last;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign emit_last = (cnt == (eight ? 3'd7 : 3'd3));

  always_comb begin
    cmd            = '{op: emr_pkg::DP_NOP, mul_sel: emr_pkg::MS_AA, default: '0};
    state_next     = state;
    cnt_next       = cnt;
    eight_next     = eight;
    done_flag_next = done_flag;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (emr_pkg::op_t'(op) == emr_pkg::OP_START) begin
            cmd.op     = emr_pkg::DP_LOAD;
            state_next = ST_SQ_A;
          end else begin
            case (stat.region)
              emr_pkg::RG_ONE: begin
                if (stat.step_less) begin
                  eight_next     = stat.diag;
                  cnt_next       = '0;
                  done_flag_next = 1'b0;
                  state_next     = ST_EMIT;
                end else begin
                  state_next = ST_XS;
                end
              end
              emr_pkg::RG_TWO: state_next = ST_CHECK;
              default:         state_next = ST_IDLE;
            endcase
          end
        end
      end
      ST_SQ_A: begin
        cmd.mul_sel = emr_pkg::MS_AA;
        state_next  = ST_SQ_B;
      end
      ST_SQ_B: begin
        cmd.op      = emr_pkg::DP_SET_A2;
        cmd.mul_sel = emr_pkg::MS_BB;
        state_next  = ST_AB;
      end
      ST_AB: begin
        cmd.op      = emr_pkg::DP_SET_B2;
        cmd.mul_sel = emr_pkg::MS_A2B;
        state_next  = ST_INIT;
      end
      ST_INIT: begin
        cmd.op         = emr_pkg::DP_INIT;
        done_flag_next = 1'b0;
        state_next     = ST_ACK;
      end
      ST_XS: begin
        cmd.mul_sel = emr_pkg::MS_XSXS;
        state_next  = ST_B2XS;
      end
      ST_B2XS: begin
        cmd.mul_sel = emr_pkg::MS_B2P;
        state_next  = ST_YS;
      end
      ST_YS: begin
        cmd.op      = emr_pkg::DP_ACC_SET;
        cmd.mul_sel = emr_pkg::MS_YSYS;
        state_next  = ST_A2YS;
      end
      ST_A2YS: begin
        cmd.mul_sel = emr_pkg::MS_A2P;
        state_next  = ST_A2B2;
      end
      ST_A2B2: begin
        cmd.op      = emr_pkg::DP_ACC_ADD;
        cmd.mul_sel = emr_pkg::MS_A2B2;
        state_next  = ST_ENTER;
      end
      ST_ENTER: begin
        cmd.op     = emr_pkg::DP_ENTER_R2;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.walk_y_neg) begin
          cmd.op         = emr_pkg::DP_FINISH;
          done_flag_next = 1'b1;
          state_next     = ST_ACK;
        end else begin
          eight_next     = stat.diag;
          cnt_next       = '0;
          done_flag_next = stat.walk_y_zero;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_point = 1'b1;
          cmd.out_idx   = cnt;
          cmd.out_last  = emit_last;
          cmd.out_done  = done_flag;
          cnt_next      = cnt + 3'd1;
          if (emit_last) begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        cmd.op     = emr_pkg::DP_UPDATE;
        state_next = ST_IDLE;
      end
      ST_ACK: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_done = done_flag;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      eight     <= 1'b0;
      done_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      eight     <= eight_next;
      done_flag <= done_flag_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/emr_datapath.sv -----
// walk registers, shared multiplier, decision terms and result register
module emr_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  emr_pkg::dp_cmd_t              cmd,
  output emr_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [emr_pkg::GRID_W-1:0]    cfg_data,
  input  logic [11:0]                   center_x,
  input  logic [11:0]                   center_y,
  input  logic [11:0]                   semi_axis_x,
  input  logic [11:0]                   semi_axis_y,
  output logic [emr_pkg::PT_W-1:0]      point_x,
  output logic [emr_pkg::PT_W-1:0]      point_y,
  output logic                          point_valid,
  output logic                          in_grid,
  output logic                          last_of_step,
  output logic                          done_res
);

  localparam int CB   = COORD_BITS;
  localparam int WW   = CB + 2;
  localparam int PW   = CB + 3;
  localparam int MW   = 2 * CB + 4;
  localparam int DW   = 4 * CB + 8;
  localparam int CMPW = (PW > emr_pkg::GRID_W) ? PW : emr_pkg::GRID_W;
  localparam logic [WW-1:0] W_ONE = WW'(1);

  logic [CB-1:0]   cx, cy, a_in, b_in;
  logic [2*CB-1:0] a2, b2;
  logic [WW-1:0]   walk_x, walk_y, last_x, last_y;
  logic [DW-1:0]   step_dx, step_dy, decision, acc, prod;
  emr_pkg::region_t region;
  logic [emr_pkg::GRID_W-1:0] grid_w, grid_h;

  // multiplier operands
  logic [WW:0]   xs, ys;
  logic [WW:0]   ys_abs;
  logic [MW-1:0] opa, opb;
  logic [DW-1:0] mul_res;

  assign xs     = {walk_x, 1'b1};
  assign ys     = {walk_y[WW-1], walk_y} - (WW+1)'(1);
  assign ys_abs = ys[WW] ? ((WW+1)'(0) - ys) : ys;

  always_comb begin
    case (cmd.mul_sel)
      emr_pkg::MS_AA:   begin opa = MW'(a_in);   opb = MW'(a_in);   end
      emr_pkg::MS_BB:   begin opa = MW'(b_in);   opb = MW'(b_in);   end
      emr_pkg::MS_A2B:  begin opa = MW'(a2);     opb = MW'(b_in);   end
      emr_pkg::MS_XSXS: begin opa = MW'(xs);     opb = MW'(xs);     end
      emr_pkg::MS_B2P:  begin opa = MW'(b2);     opb = prod[MW-1:0]; end
      emr_pkg::MS_YSYS: begin opa = MW'(ys_abs); opb = MW'(ys_abs); end
      emr_pkg::MS_A2P:  begin opa = MW'(a2);     opb = prod[MW-1:0]; end
      emr_pkg::MS_A2B2: begin opa = MW'(a2);     opb = MW'(b2);     end
      default:          begin opa = '0;          opb = '0;          end
    endcase
  end

  assign mul_res = opa * opb;

  // step terms
  logic [DW-1:0] a2e, b2e, sdx_n, sdy_n;
  logic [WW-1:0] wy_dec, ddx, ddy;

  assign a2e    = DW'(a2);
  assign b2e    = DW'(b2);
  assign sdx_n  = step_dx + {b2e[DW-2:0], 1'b0};
  assign sdy_n  = step_dy - {a2e[DW-2:0], 1'b0};
  assign wy_dec = walk_y - W_ONE;
  assign ddx    = walk_x - last_x;
  assign ddy    = walk_y - last_y;

  assign stat.region      = region;
  assign stat.step_less   = $signed(step_dx) < $signed(step_dy);
  assign stat.walk_y_neg  = walk_y[WW-1];
  assign stat.walk_y_zero = (walk_y == '0);
  assign stat.diag        = (ddx == W_ONE || ddx == '1) && (ddy == W_ONE || ddy == '1);

  always_ff @(posedge clk) begin
    prod <= mul_res;
    case (cmd.op)
      emr_pkg::DP_LOAD: begin
        cx   <= CB'(center_x);
        cy   <= CB'(center_y);
        a_in <= CB'(semi_axis_x);
        b_in <= CB'(semi_axis_y);
      end
      emr_pkg::DP_SET_A2: a2 <= prod[2*CB-1:0];
      emr_pkg::DP_SET_B2: b2 <= prod[2*CB-1:0];
      emr_pkg::DP_INIT: begin
        // prod holds a2 * b here
        step_dx  <= '0;
        step_dy  <= {prod[DW-2:0], 1'b0};
        decision <= b2e - prod + DW'(a2 >> 2);
        walk_x   <= '0;
        walk_y   <= WW'(b_in);
        last_x   <= '0;
        last_y   <= WW'(b_in);
      end
      emr_pkg::DP_ACC_SET: acc <= prod >> 2;
      emr_pkg::DP_ACC_ADD: acc <= acc + prod;
      emr_pkg::DP_ENTER_R2: decision <= acc - prod;
      emr_pkg::DP_UPDATE: begin
        last_x <= walk_x;
        last_y <= walk_y;
        if (region == emr_pkg::RG_ONE) begin
          walk_x  <= walk_x + W_ONE;
          step_dx <= sdx_n;
          if (decision[DW-1]) begin
            decision <= decision + sdx_n + b2e;
          end else begin
            walk_y   <= wy_dec;
            step_dy  <= sdy_n;
            decision <= decision + sdx_n - sdy_n + b2e;
          end
        end else begin
          walk_y  <= wy_dec;
          step_dy <= sdy_n;
          if (!decision[DW-1] && decision != '0) begin
            decision <= decision + a2e - sdy_n;
          end else begin
            walk_x   <= walk_x + W_ONE;
            step_dx  <= sdx_n;
            decision <= decision + sdx_n - sdy_n + a2e;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region <= emr_pkg::RG_IDLE;
    end else begin
      case (cmd.op)
        emr_pkg::DP_INIT:     region <= emr_pkg::RG_ONE;
        emr_pkg::DP_ENTER_R2: region <= emr_pkg::RG_TWO;
        emr_pkg::DP_FINISH:   region <= emr_pkg::RG_DONE;
        emr_pkg::DP_UPDATE: begin
          if (region == emr_pkg::RG_TWO && wy_dec[WW-1]) begin
            region <= emr_pkg::RG_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= emr_pkg::GRID_RESET;
      grid_h <= emr_pkg::GRID_RESET;
    end else if (cfg_we) begin
      case (emr_pkg::reg_idx_t'(cfg_index))
        emr_pkg::REG_GRID_WIDTH:  grid_w <= cfg_data;
        emr_pkg::REG_GRID_HEIGHT: grid_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // point generation: set 1 is the corrector offset
  logic [WW-1:0] ox, oy;
  logic [PW-1:0] cxe, cye, oxe, oye, px, py;
  logic          px_in;

  always_comb begin
    ox = walk_x;
    oy = walk_y;
    if (cmd.out_idx[2]) begin
      if (region == emr_pkg::RG_ONE) begin
        ox = last_x;
      end else begin
        oy = last_y;
      end
    end
  end

  assign cxe   = PW'(cx);
  assign cye   = PW'(cy);
  assign oxe   = {ox[WW-1], ox};
  assign oye   = {oy[WW-1], oy};
  assign px    = cmd.out_idx[0] ? (cxe - oxe) : (cxe + oxe);
  assign py    = cmd.out_idx[1] ? (cye - oye) : (cye + oye);
  assign px_in = !px[PW-1] && !py[PW-1] &&
                 (CMPW'(px) < CMPW'(grid_w)) && (CMPW'(py) < CMPW'(grid_h));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_valid  <= cmd.out_point;
      last_of_step <= cmd.out_last;
      done_res     <= cmd.out_done;
      if (cmd.out_point) begin
        point_x <= emr_pkg::PT_W'($signed(px));
        point_y <= emr_pkg::PT_W'($signed(py));
        in_grid <= px_in;
      end else begin
        point_x <= '0;
        point_y <= '0;
        in_grid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/ellipse_midpoint_rasterizer.sv -----
// top level: two-region midpoint ellipse walk with 4-connected outline
// start: loads the operands, forms three products on one multiplier, then sends an ack beat
// advance: 4 or 8 point beats, one per cycle while the output slot is free, then an update state before the next input
// region change first runs the region-two decision products on the shared multiplier before the first point
// in_ready is high only while the controller is idle; one output register holds a beat
// synchronous active-high reset: grid registers to 4096, no ellipse loaded, output empty
module ellipse_midpoint_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration writes
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [12:0]                cfg_data,
  // input beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [11:0]                center_x,
  input  logic [11:0]                center_y,
  input  logic [11:0]                semi_axis_x,
  input  logic [11:0]                semi_axis_y,
  // result beats
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [13:0]         point_x,
  output logic signed [13:0]         point_y,
  output logic                       point_valid,
  output logic                       in_grid,
  output logic                       last_of_step,
  output logic                       done_res
);

  emr_pkg::dp_cmd_t  cmd;
  emr_pkg::dp_stat_t stat;
  logic [13:0]       px_raw, py_raw;

  // controller sequences multiplies, emission and the walk update
  emr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath holds the walk state, grid size and the output register
  emr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .center_x     (center_x),
    .center_y     (center_y),
    .semi_axis_x  (semi_axis_x),
    .semi_axis_y  (semi_axis_y),
    .point_x      (px_raw),
    .point_y      (py_raw),
    .point_valid  (point_valid),
    .in_grid      (in_grid),
    .last_of_step (last_of_step),
    .done_res     (done_res)
  );

  assign point_x = $signed(px_raw);
  assign point_y = $signed(py_raw);

endmodule
